@@ rtl/core/n_plate_radiation_pressure_force_unit_macros.svh @@
// Assertion macros for the n-plate radiation pressure force RTL
`ifndef N_PLATE_RADIATION_PRESSURE_FORCE_UNIT_MACROS_SVH
`define N_PLATE_RADIATION_PRESSURE_FORCE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NPRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NPRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nprp_pkg.sv @@
// Shared constants and types for the n-plate radiation pressure force unit
package nprp_pkg;

    localparam int NPRP_MAX_PLATES = 64;

    localparam int FORCE_W = 48;
    localparam int ACC_W   = 64;
    localparam int POM_W   = 32;
    localparam int CNT_CFG_W = 7;

    // configuration register indexes
    localparam logic CFG_PLATE_COUNT = 1'b0;
    localparam logic CFG_POM         = 1'b1;

    // item kinds
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    // plate entry: area, specular, diffuse, normal z/y/x
    localparam int ENTRY_W = 96;

    typedef logic signed [ACC_W-1:0] acc_t;

    // control from the sequencer to the plate datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } pipe_ctl_t;

endpackage

@@ rtl/core/nprp_plate_pipe.sv @@
// Plate table memory and the per-plate force accumulation pipeline
module nprp_plate_pipe #(
    parameter int MAX_PLATES = nprp_pkg::NPRP_MAX_PLATES,
    parameter int AW = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nprp_pkg::pipe_ctl_t           ctl,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [nprp_pkg::ENTRY_W-1:0]  wr_data,
    input  logic [AW-1:0]                 rd_addr,
    input  logic signed [15:0]            sun_x,
    input  logic signed [15:0]            sun_y,
    input  logic signed [15:0]            sun_z,
    output nprp_pkg::acc_t                acc_x,
    output nprp_pkg::acc_t                acc_y,
    output nprp_pkg::acc_t                acc_z,
    output logic                          busy
);
    import nprp_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_PLATES];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [8:1]         vld_reg;

    logic signed [15:0] s [3];

    // stage 1 -> 2
    logic signed [31:0] p_reg [3];
    logic [15:0]        area2_reg, spec2_reg, diff2_reg;
    logic signed [15:0] n2_reg [3];
    // stage 2 -> 3
    logic [17:0]        c15_reg;
    logic [15:0]        area3_reg, spec3_reg, diff3_reg;
    logic signed [15:0] n3_reg [3];
    // stage 3 -> 4
    logic [33:0]        ga_reg;
    logic [29:0]        d3_reg;
    logic [33:0]        w4_reg;
    logic [16:0]        om_reg;
    logic signed [15:0] n4_reg [3];
    // stage 4 -> 5
    logic [34:0]        g_reg;
    logic signed [33:0] ts_reg [3];
    logic [33:0]        w5_reg;
    logic signed [15:0] n5_reg [3];
    // stage 5 -> 6
    logic signed [52:0] v_reg [3];
    logic [33:0]        w6_reg;
    // stage 6 -> 7
    logic signed [21:0] v15_reg [3];
    logic [33:0]        w7_reg;
    // stage 7 -> 8
    logic signed [56:0] prod_reg [3];

    acc_t acc_reg [3];

    logic signed [33:0] dot;
    logic [32:0]        cmag;
    logic [62:0]        d3_full;
    logic signed [51:0] gn [3];
    logic signed [52:0] v_next [3];
    logic signed [52:0] vr [3];

    assign s[0] = sun_x;
    assign s[1] = sun_y;
    assign s[2] = sun_z;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // valid tracking; unlit plates drop out after the dot product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg[1] <= ctl.rd_en;
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2] && dot[33];
            vld_reg[8:4] <= vld_reg[7:3];
        end
    end

    assign busy = |vld_reg;

    // combinational pieces of each stage
    always_comb
    begin
        dot = 34'(p_reg[0]) + 34'(p_reg[1]) + 34'(p_reg[2]);
        cmag = 33'(-dot);
        d3_full = 63'({diff3_reg, 15'd0}) * 63'(32'hAAAAAAAB);
        for (int k = 0; k < 3; k++)
        begin
            gn[k] = $signed({1'b0, g_reg}) * n5_reg[k];
            v_next[k] = (53'(ts_reg[k]) <<< 15) - (53'(gn[k]) <<< 1);
            vr[k] = v_reg[k] + 53'(64'sd1 <<< 30);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // stage 1: component products of n.s
        area2_reg <= rdata_reg[95:80];
        spec2_reg <= rdata_reg[79:64];
        diff2_reg <= rdata_reg[63:48];
        for (int k = 0; k < 3; k++)
        begin
            n2_reg[k] <= $signed(rdata_reg[16*k +: 16]);
            p_reg[k]  <= $signed(rdata_reg[16*k +: 16]) * s[k];
        end
        // stage 2: cosine, rounded to Q2.15
        c15_reg   <= 18'((cmag + 33'd16384) >> 15);
        area3_reg <= area2_reg;
        spec3_reg <= spec2_reg;
        diff3_reg <= diff2_reg;
        n3_reg    <= n2_reg;
        // stage 3: spec*c, diff/3 by reciprocal, area*c
        ga_reg <= 34'(spec3_reg) * 34'(c15_reg);
        d3_reg <= d3_full[62:33];
        w4_reg <= 34'(area3_reg) * 34'(c15_reg);
        om_reg <= 17'h10000 - 17'(spec3_reg);
        n4_reg <= n3_reg;
        // stage 4: g and (1-spec)*s
        g_reg <= 35'(ga_reg) + 35'(d3_reg);
        for (int k = 0; k < 3; k++)
        begin
            ts_reg[k] <= $signed({1'b0, om_reg}) * s[k];
        end
        w5_reg <= w4_reg;
        n5_reg <= n4_reg;
        // stage 5: direction term
        v_reg  <= v_next;
        w6_reg <= w5_reg;
        // stage 6: round to Q.15
        for (int k = 0; k < 3; k++)
        begin
            v15_reg[k] <= 22'(vr[k] >>> 31);
        end
        w7_reg <= w6_reg;
        // stage 7: weight by area*c
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= v15_reg[k] * $signed({1'b0, w7_reg});
        end
    end

    // stage 8: accumulate
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (ctl.clr)
            begin
                acc_reg[k] <= '0;
            end
            else if (vld_reg[8])
            begin
                acc_reg[k] <= acc_reg[k] + ACC_W'(prod_reg[k]);
            end
        end
    end

    assign acc_x = acc_reg[0];
    assign acc_y = acc_reg[1];
    assign acc_z = acc_reg[2];

endmodule

@@ rtl/core/nprp_scale.sv @@
// Scales one accumulator component by pressure over mass, rounds and saturates
module nprp_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  nprp_pkg::acc_t                    acc_in,
    input  logic [nprp_pkg::POM_W-1:0]        pom,
    output logic                              done,
    output logic signed [nprp_pkg::FORCE_W-1:0] force_out,
    output logic                              sat
);
    import nprp_pkg::*;

    localparam logic [ACC_W-1:0] POS_MAX = ACC_W'((64'd1 << (FORCE_W - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] NEG_MAG = ACC_W'(64'd1 << (FORCE_W - 1));

    logic [2:0]         vld_reg;
    logic [ACC_W-1:0]   mag_reg;
    logic               neg1_reg, neg2_reg;
    logic [63:0]        lo_reg, hi_reg;
    logic [ACC_W-1:0]   r;
    logic [ACC_W-1:0]   rc;
    logic               clip;
    logic [64:0]        lo_rnd;
    logic signed [FORCE_W-1:0] force_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    // round and clip to the signed 48-bit range
    always_comb
    begin
        lo_rnd = 65'(lo_reg) + 65'h80000000;
        r = hi_reg + 64'(lo_rnd >> 32);
        clip = neg2_reg ? (r > NEG_MAG) : (r > POS_MAX);
        if (clip)
        begin
            rc = neg2_reg ? NEG_MAG : POS_MAX;
        end
        else
        begin
            rc = r;
        end
    end

    always_ff @(posedge clk)
    begin
        // magnitude
        neg1_reg <= acc_in[ACC_W-1];
        mag_reg  <= acc_in[ACC_W-1] ? (ACC_W'(0) - acc_in) : acc_in;
        // two 32x32 partial products
        neg2_reg <= neg1_reg;
        lo_reg   <= 64'(mag_reg[31:0]) * 64'(pom);
        hi_reg   <= 64'(mag_reg[63:32]) * 64'(pom);
        // final
        force_reg <= neg2_reg ? FORCE_W'(ACC_W'(0) - rc) : FORCE_W'(rc);
        sat_reg   <= clip;
    end

    assign done      = vld_reg[2];
    assign force_out = force_reg;
    assign sat       = sat_reg;

endmodule

@@ rtl/core/n_plate_radiation_pressure_force_unit.sv @@
// Top level of the n-plate solar radiation pressure force unit
//
// Input channel (in_valid / in_stall) carries one item per transfer. A plate
// write (kind = 0) stores one plate entry and gives no result; a plate_index
// at or beyond MAX_PLATES is dropped. A compute item (kind = 1) carries the
// sun direction and produces one force result. A compute reads the plate
// table one entry per cycle through a single memory port into an 8-stage
// arithmetic pipeline: it issues N = min(plate_count, MAX_PLATES) entries,
// waits for the pipeline to drain, runs three scaling passes (one per axis)
// and loads the output register. in_stall stays high while a compute runs.
// Output channel (out_valid / out_stall) is a result register. While the
// receiver stalls, the result holds and the next write items are still
// taken; a following compute finishes and waits to load until it frees.
// Reset clears the registers plate_count and pressure_over_mass and all
// control; plate entries are undefined until written.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle; the block itself does not enforce this.
module n_plate_radiation_pressure_force_unit #(
    parameter int MAX_PLATES = nprp_pkg::NPRP_MAX_PLATES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [nprp_pkg::POM_W-1:0]           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [5:0]                           plate_index,
    input  logic [15:0]                          area,
    input  logic [15:0]                          specular_coef,
    input  logic [15:0]                          diffuse_coef,
    input  logic signed [15:0]                   normal_x,
    input  logic signed [15:0]                   normal_y,
    input  logic signed [15:0]                   normal_z,
    input  logic signed [15:0]                   sun_x,
    input  logic signed [15:0]                   sun_y,
    input  logic signed [15:0]                   sun_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [nprp_pkg::FORCE_W-1:0]  force_x,
    output logic signed [nprp_pkg::FORCE_W-1:0]  force_y,
    output logic signed [nprp_pkg::FORCE_W-1:0]  force_z,
    output logic                                 saturated
);
    import nprp_pkg::*;

    `include "n_plate_radiation_pressure_force_unit_macros.svh"

    localparam int AW = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;
    localparam int CW = $clog2(MAX_PLATES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_SWAIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        num_reg, num_next;
    logic [1:0]           axis_reg, axis_next;
    logic [CNT_CFG_W-1:0] plate_count_reg;
    logic [POM_W-1:0]     pom_reg;
    logic signed [15:0]   sun_reg [3];
    logic signed [FORCE_W-1:0] f_reg [3];
    logic                 sat_reg;
    logic                 out_valid_reg;
    logic signed [FORCE_W-1:0] out_f_reg [3];
    logic                 out_sat_reg;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 wr_item;
    logic                 cmp_item;
    logic                 load_out;
    logic [CW-1:0]        num_eff;
    pipe_ctl_t            ctl;
    acc_t                 acc_x, acc_y, acc_z, acc_sel;
    logic                 pipe_busy;
    logic                 sc_start, sc_done, sc_sat;
    logic signed [FORCE_W-1:0] sc_force;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign wr_item  = in_xfer && (kind == KIND_WRITE);
    assign cmp_item = in_xfer && (kind == KIND_COMPUTE);

    // active plate count, capped at the table depth
    always_comb
    begin
        if (32'(plate_count_reg) > 32'(MAX_PLATES))
        begin
            num_eff = CW'(MAX_PLATES);
        end
        else
        begin
            num_eff = CW'(plate_count_reg);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_count_reg <= '0;
            pom_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLATE_COUNT: plate_count_reg <= cfg_wdata[CNT_CFG_W-1:0];
                CFG_POM:         pom_reg <= cfg_wdata;
                default:         pom_reg <= pom_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        axis_next  = axis_reg;
        ctl.wr_en  = wr_item && (32'(plate_index) < 32'(MAX_PLATES));
        ctl.rd_en  = 1'b0;
        ctl.clr    = cmp_item;
        sc_start   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmp_item)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    num_next   = num_eff;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == num_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_SCALE;
                    axis_next  = 2'd0;
                end
            end
            ST_SCALE:
            begin
                sc_start   = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                if (sc_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            num_reg   <= num_next;
            axis_reg  <= axis_next;
        end
    end

    // sun direction held for the whole compute
    always_ff @(posedge clk)
    begin
        if (cmp_item)
        begin
            sun_reg[0] <= sun_x;
            sun_reg[1] <= sun_y;
            sun_reg[2] <= sun_z;
        end
    end

    nprp_plate_pipe #(
        .MAX_PLATES (MAX_PLATES),
        .AW         (AW)
    ) u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_addr (AW'(plate_index)),
        .wr_data ({area, specular_coef, diffuse_coef, normal_z, normal_y, normal_x}),
        .rd_addr (cnt_reg[AW-1:0]),
        .sun_x   (sun_reg[0]),
        .sun_y   (sun_reg[1]),
        .sun_z   (sun_reg[2]),
        .acc_x   (acc_x),
        .acc_y   (acc_y),
        .acc_z   (acc_z),
        .busy    (pipe_busy)
    );

    always_comb
    begin
        case (axis_reg)
            2'd0:    acc_sel = acc_x;
            2'd1:    acc_sel = acc_y;
            default: acc_sel = acc_z;
        endcase
    end

    nprp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sc_start),
        .acc_in    (acc_sel),
        .pom       (pom_reg),
        .done      (sc_done),
        .force_out (sc_force),
        .sat       (sc_sat)
    );

    // collect scaled components
    always_ff @(posedge clk)
    begin
        if (sc_done)
        begin
            f_reg[axis_reg] <= sc_force;
            sat_reg <= (axis_reg == 2'd0) ? sc_sat : (sat_reg | sc_sat);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_f_reg   <= f_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = out_f_reg[0];
    assign force_y   = out_f_reg[1];
    assign force_z   = out_f_reg[2];
    assign saturated = out_sat_reg;

    `NPRP_ASSERT_NEXT(a_cmp_starts_run, cmp_item, state_reg == ST_RUN,
        "compute transfer did not start the plate walk")
    `NPRP_ASSERT_NOW(a_rd_in_range, ctl.rd_en, cnt_reg < num_reg,
        "plate read beyond the active count")
    `NPRP_ASSERT_NOW(a_scale_after_drain, sc_start, !pipe_busy,
        "scaling started while the plate pipeline still held items")
    `NPRP_ASSERT_NOW(a_no_load_over_pending, load_out && out_valid_reg, !out_stall,
        "result register overwritten while stalled")

endmodule
